### rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker of the sort engine.
// Depends on nothing; each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed in the following cycle");

`endif

### rtl/core/asre_pkg.sv
// Package for the array sort and reverse engine: sizes, command codes, item types, states.
// Depends on nothing; used by the top level and its checker.
package asre_pkg;

    localparam int MAX_LENGTH = 64;
    localparam int IDX_W      = $clog2(MAX_LENGTH);
    localparam int LEN_W      = 7;
    localparam int DATA_W     = 32;
    localparam int CMD_W      = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE     = 3'd0,
        CMD_READ      = 3'd1,
        CMD_SORT_UP   = 3'd2,
        CMD_SORT_DOWN = 3'd3,
        CMD_REVERSE   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [IDX_W-1:0]         element_index;
        logic signed [DATA_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     status;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_DATA,
        ST_SORT_CARRY,
        ST_SORT_CMP,
        ST_SORT_END,
        ST_REV_HI,
        ST_REV_WR_LO,
        ST_REV_WR_HI
    } t_state;

endpackage

### rtl/core/array_sort_reverse_engine.sv
// Top level of the array sort and reverse engine: element memory, command sequencer,
// result register. Depends on asre_pkg.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_stall   i_in_item  (asre_pkg::t_in_item)
//   out       output     o_out_valid / i_out_stall o_out_item (asre_pkg::t_out_item)
//   cfg       input      i_cfg_wr_en               i_cfg_wr_data (array length)
//
// Write, unknown, out-of-range items and sorts or reverses of fewer than two elements finish
// in the accept cycle; a read in range loads its result from ST_READ_DATA.
// A sort of n elements runs pass by pass through the single memory read port; within a pass
// one compare-and-swap issues per cycle, with the carried element held in a register.
// A reverse of n elements reads and then writes both elements of each swapped pair.
// Reset is synchronous and active low; the element memory is not cleared.
// A stalled result holds the output register; a new item is taken once that register drains.
module array_sort_reverse_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  asre_pkg::t_in_item         i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output asre_pkg::t_out_item        o_out_item,
    input  logic                       i_cfg_wr_en,
    input  logic [asre_pkg::LEN_W-1:0] i_cfg_wr_data
);
    import asre_pkg::*;

    t_state                   r_state, n_state;
    logic [LEN_W-1:0]         r_len;
    logic [IDX_W-1:0]         r_k, n_k;
    logic [IDX_W-1:0]         r_last, n_last;
    logic signed [DATA_W-1:0] r_carry, n_carry;
    logic                     r_desc, n_desc;
    logic                     r_out_valid;
    t_out_item                r_out_item;

    logic signed [DATA_W-1:0] r_mem [MAX_LENGTH];
    logic signed [DATA_W-1:0] r_rd_data;
    logic [IDX_W-1:0]         mem_raddr;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;

    logic [LEN_W-1:0]         used_len;
    logic                     in_accept;
    logic                     idx_ok;
    logic                     swap;
    logic [IDX_W-1:0]         k_plus1;
    logic                     rev_more;
    logic                     out_load;
    t_out_item                out_item;

    assign used_len   = (r_len > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : r_len;
    assign o_in_stall = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign idx_ok     = {1'b0, i_in_item.element_index} < used_len;
    assign swap       = r_desc ? (r_rd_data > r_carry) : (r_carry > r_rd_data);
    assign k_plus1    = r_k + IDX_W'(1);
    assign rev_more   = ({1'b0, r_k} + (IDX_W+1)'(1)) < ({1'b0, r_last} - (IDX_W+1)'(1));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_k     <= n_k;
        r_last  <= n_last;
        r_carry <= n_carry;
        r_desc  <= n_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cfg_wr_en) begin
            r_len <= i_cfg_wr_data;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_last    = r_last;
        n_carry   = r_carry;
        n_desc    = r_desc;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        out_load  = 1'b0;
        out_item  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (i_in_item.command) inside
                        CMD_WRITE: begin
                            out_load = 1'b1;
                            if (idx_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = i_in_item.element_index;
                                mem_wdata = i_in_item.element_value;
                            end else begin
                                out_item.status = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            if (idx_ok) begin
                                mem_raddr = i_in_item.element_index;
                                n_state   = ST_READ_DATA;
                            end else begin
                                out_load        = 1'b1;
                                out_item.status = 1'b1;
                            end
                        end
                        CMD_SORT_UP, CMD_SORT_DOWN, CMD_REVERSE: begin
                            if (used_len < LEN_W'(2)) begin
                                out_load = 1'b1;
                            end else begin
                                n_desc    = (i_in_item.command == CMD_SORT_DOWN);
                                n_k       = '0;
                                n_last    = IDX_W'(used_len - LEN_W'(1));
                                mem_raddr = '0;
                                n_state   = (i_in_item.command == CMD_REVERSE) ? ST_REV_HI
                                                                             : ST_SORT_CARRY;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ_DATA: begin
                out_load            = 1'b1;
                out_item.read_value = r_rd_data;
                n_state             = ST_IDLE;
            end
            ST_SORT_CARRY: begin
                n_carry   = r_rd_data;
                mem_raddr = k_plus1;
                n_state   = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = r_k;
                mem_wdata = swap ? r_rd_data : r_carry;
                n_carry   = swap ? r_carry : r_rd_data;
                if (k_plus1 == r_last) begin
                    n_state = ST_SORT_END;
                end else begin
                    n_k       = k_plus1;
                    mem_raddr = r_k + IDX_W'(2);
                end
            end
            ST_SORT_END: begin
                mem_we    = 1'b1;
                mem_waddr = r_last;
                mem_wdata = r_carry;
                if (r_last == IDX_W'(1)) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_last    = r_last - IDX_W'(1);
                    n_k       = '0;
                    mem_raddr = '0;
                    n_state   = ST_SORT_CARRY;
                end
            end
            ST_REV_HI: begin
                n_carry   = r_rd_data;
                mem_raddr = r_last;
                n_state   = ST_REV_WR_LO;
            end
            ST_REV_WR_LO: begin
                mem_we    = 1'b1;
                mem_waddr = r_k;
                mem_wdata = r_rd_data;
                n_state   = ST_REV_WR_HI;
            end
            ST_REV_WR_HI: begin
                mem_we    = 1'b1;
                mem_waddr = r_last;
                mem_wdata = r_carry;
                if (rev_more) begin
                    n_k       = k_plus1;
                    n_last    = r_last - IDX_W'(1);
                    mem_raddr = k_plus1;
                    n_state   = ST_REV_HI;
                end else begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_item <= out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/core/asre_checker.sv
// Port-level checker for the array sort and reverse engine, bound to the top level.
// Depends on asre_pkg and assert_macros.svh.
`include "assert_macros.svh"

module asre_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_stall,
    input asre_pkg::t_in_item  i_in_item,
    input logic                i_out_valid,
    input logic                i_out_stall,
    input asre_pkg::t_out_item i_out_item
);
    import asre_pkg::*;

    logic out_held;
    logic flagged;
    logic write_taken;

    assign out_held    = i_out_valid && i_out_stall;
    assign flagged     = i_out_valid && i_out_item.status;
    assign write_taken = i_in_valid && !i_in_stall && (i_in_item.command == CMD_WRITE);

    // A stalled result stays and keeps its payload.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, i_out_valid && $stable(i_out_item))

    // An out-of-range flag never comes with a read value.
    `ASSERT_SAME(a_status_zero, i_clk, i_rst_n, flagged, i_out_item.read_value == '0)

    // No item is taken while a finished result is held back.
    `ASSERT_SAME(a_no_take_blocked, i_clk, i_rst_n, out_held, i_in_stall)

    // A write gives its result in the next cycle.
    `ASSERT_NEXT(a_write_result, i_clk, i_rst_n, write_taken, i_out_valid)

endmodule

bind array_sort_reverse_engine asre_checker u_asre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);

### test/asre_result_checker.sv
// Result checker for the array sort and reverse engine: predicts each result and compares it.
// Depends on asre_pkg; it only watches the channels and the length register port of the block.
module asre_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  asre_pkg::t_in_item         i_in_item,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  asre_pkg::t_out_item        i_out_item,
    input  logic                       i_cfg_wr_en,
    input  logic [asre_pkg::LEN_W-1:0] i_cfg_wr_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    import asre_pkg::*;

    logic signed [DATA_W-1:0] shadow_store [MAX_LENGTH];
    logic [LEN_W-1:0]         length_reg;
    t_out_item                awaited_results [$];
    t_out_item                head_result;
    int                       fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic int used_count();
        return (length_reg > MAX_LENGTH) ? MAX_LENGTH : int'(length_reg);
    endfunction

    function automatic t_out_item apply_command(t_in_item it);
        t_out_item                r;
        int                       n;
        logic signed [DATA_W-1:0] held;
        logic                     do_swap;
        r = '0;
        n = used_count();
        case (it.command)
            CMD_WRITE: begin
                if (it.element_index < n) begin
                    shadow_store[it.element_index] = it.element_value;
                end else begin
                    r.status = 1'b1;
                end
            end
            CMD_READ: begin
                if (it.element_index < n) begin
                    r.read_value = shadow_store[it.element_index];
                end else begin
                    r.status = 1'b1;
                end
            end
            CMD_SORT_UP, CMD_SORT_DOWN: begin
                for (int pass = 0; pass + 1 < n; pass++) begin
                    for (int k = 0; k + 1 < n - pass; k++) begin
                        do_swap = (it.command == CMD_SORT_UP) ?
                                  (shadow_store[k] > shadow_store[k+1]) :
                                  (shadow_store[k+1] > shadow_store[k]);
                        if (do_swap) begin
                            held              = shadow_store[k];
                            shadow_store[k]   = shadow_store[k+1];
                            shadow_store[k+1] = held;
                        end
                    end
                end
            end
            CMD_REVERSE: begin
                for (int k = 0; k < n / 2; k++) begin
                    held                = shadow_store[k];
                    shadow_store[k]     = shadow_store[n-1-k];
                    shadow_store[n-1-k] = held;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            length_reg <= '0;
            awaited_results.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result with nothing expected: read_value %0d status %0d",
                           i_out_item.read_value, i_out_item.status);
                    fail_count++;
                end else begin
                    head_result = awaited_results.pop_front();
                    if (i_out_item.read_value !== head_result.read_value) begin
                        $error("read_value: expected %0d, actual %0d",
                               head_result.read_value, i_out_item.read_value);
                        fail_count++;
                    end
                    if (i_out_item.status !== head_result.status) begin
                        $error("status: expected %0d, actual %0d",
                               head_result.status, i_out_item.status);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(apply_command(i_in_item));
            end
            if (i_cfg_wr_en) begin
                length_reg <= i_cfg_wr_data;
            end
            o_pending <= awaited_results.size();
        end
    end

endmodule

### test/tb_array_sort_reverse_engine.sv
// Testbench top for the array sort and reverse engine: clock, reset, stimulus and verdict.
// Depends on asre_pkg, array_sort_reverse_engine and asre_result_checker.
module tb_array_sort_reverse_engine;
    import asre_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 9;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in_item;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_item        o_out_item;
    logic             i_cfg_wr_en;
    logic [LEN_W-1:0] i_cfg_wr_data;
    int               fail_count;
    int               pending;

    bit   written [MAX_LENGTH];
    int   live_len    = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   hold_asks   = 0;
    int   hold_done   = 0;

    int phase_len   [PHASES] = '{6, 2, 127, 1, 13, 65, 0, 4, 9};
    int phase_items [PHASES] = '{14, 8, 41, 6, 16, 10, 4, 8, 10};

    array_sort_reverse_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    asre_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_item    (o_out_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("tb_array_sort_reverse_engine NOT OK");
        $finish;
    end

    // The receiver stalls at random, or for one long stretch when asked to.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    function automatic t_in_item make_item(logic [CMD_W-1:0] cmd, int idx,
                                           logic signed [DATA_W-1:0] val);
        t_in_item it;
        it.command       = cmd;
        it.element_index = idx[IDX_W-1:0];
        it.element_value = val;
        return it;
    endfunction

    function automatic int first_unwritten();
        for (int k = 0; k < live_len; k++) begin
            if (!written[k]) return k;
        end
        return -1;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2, 3:    return $signed($urandom_range(0, 4)) - 2;
            default: return $urandom;
        endcase
    endfunction

    // Reads and sorts only touch elements that were written before.
    function automatic t_in_item pick_item();
        t_in_item it;
        int       roll;
        int       gap;
        it  = make_item(CMD_WRITE, $urandom_range(0, MAX_LENGTH - 1), pick_value());
        gap = first_unwritten();
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            it.command = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        end else if (roll < 10 && live_len < MAX_LENGTH) begin
            it.command       = roll[0] ? CMD_READ : CMD_WRITE;
            it.element_index = IDX_W'($urandom_range(live_len, MAX_LENGTH - 1));
        end else if (roll < 45) begin
            if (gap >= 0 && $urandom_range(0, 1)) begin
                it.element_index = IDX_W'(gap);
            end else if (live_len > 0) begin
                it.element_index = IDX_W'($urandom_range(0, live_len - 1));
            end
        end else if (roll < 70) begin
            if (gap == 0) begin
                it.element_index = IDX_W'(gap);
            end else begin
                it.command = CMD_READ;
                if (gap > 0) begin
                    it.element_index = IDX_W'($urandom_range(0, gap - 1));
                end else if (live_len > 0) begin
                    it.element_index = IDX_W'($urandom_range(0, live_len - 1));
                end
            end
        end else if (gap >= 0) begin
            it.element_index = IDX_W'(gap);
        end else begin
            it.command = CMD_W'($urandom_range(CMD_SORT_UP, CMD_REVERSE));
        end
        return it;
    endfunction

    task automatic send(t_in_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (it.command == CMD_WRITE && it.element_index < live_len) begin
            written[it.element_index] = 1'b1;
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_length(int value);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value[LEN_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        live_len = (value > MAX_LENGTH) ? MAX_LENGTH : value;
    endtask

    initial begin
        int c;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty array: every index is out of range and sorts do nothing.
        set_length(0);
        send(make_item(CMD_WRITE, 0, 5));
        send(make_item(CMD_READ, MAX_LENGTH - 1, 0));
        send(make_item(CMD_SORT_UP, 0, 0));
        send(make_item(CMD_SORT_DOWN, 0, 0));
        send(make_item(CMD_REVERSE, 0, 0));
        for (c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
            send(make_item(c[CMD_W-1:0], 0, 0));
        end

        // Two elements at the value extremes, then equal neighbours.
        set_length(2);
        send(make_item(CMD_WRITE, 0, 32'sh7FFF_FFFF));
        send(make_item(CMD_WRITE, 1, 32'sh8000_0000));
        send(make_item(CMD_WRITE, 2, 7));
        send(make_item(CMD_READ, MAX_LENGTH - 1, 0));
        send(make_item(CMD_READ, 0, 0));
        send(make_item(CMD_READ, 1, 0));
        send(make_item(CMD_SORT_UP, 0, 0));
        send(make_item(CMD_READ, 0, 0));
        send(make_item(CMD_SORT_DOWN, 0, 0));
        send(make_item(CMD_READ, 0, 0));
        send(make_item(CMD_REVERSE, 0, 0));
        send(make_item(CMD_READ, 1, 0));
        send(make_item(CMD_WRITE, 1, 32'sh7FFF_FFFF));
        send(make_item(CMD_SORT_UP, 0, 0));
        send(make_item(CMD_READ, 0, 0));

        for (int p = 0; p < PHASES; p++) begin
            set_length(phase_len[p]);
            if (p < 3) begin
                tx_idle_pct = 26;
                rx_idle_pct <= 55;
            end else if (p < 6) begin
                tx_idle_pct = 55;
                rx_idle_pct <= 26;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            for (int n = 0; n < phase_items[p]; n++) begin
                if (p == 0 && n == 4) begin
                    hold_asks++;
                end
                if (p == 4 && n == 8) begin
                    settle();
                end
                send(pick_item());
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_array_sort_reverse_engine OK");
        end else begin
            $display("tb_array_sort_reverse_engine NOT OK");
        end
        $finish;
    end

endmodule
